@@ design/wsfd_pkg.sv @@
package wsfd_pkg;

  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  localparam logic [2:0] CLS_TEXT    = 3'd0;
  localparam logic [2:0] CLS_BINARY  = 3'd1;
  localparam logic [2:0] CLS_CLOSE   = 3'd2;
  localparam logic [2:0] CLS_PING    = 3'd3;
  localparam logic [2:0] CLS_PONG    = 3'd4;
  localparam logic [2:0] CLS_UNKNOWN = 3'd5;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  typedef enum logic [4:0] {
    PH_HDR0 = 5'b00001,
    PH_HDR1 = 5'b00010,
    PH_EXT  = 5'b00100,
    PH_KEY  = 5'b01000,
    PH_DATA = 5'b10000
  } phase_t;

  typedef struct packed {
    logic       has_data;
    logic [7:0] data_byte;
    logic [2:0] frame_class;
    logic       frame_last;
    logic       fin_flag;
    logic       closing;
  } res_t;

  function automatic logic [2:0] class_of(input logic [3:0] opcode);
    logic [2:0] cls;
    unique case (opcode)
      OP_TEXT:   cls = CLS_TEXT;
      OP_BINARY: cls = CLS_BINARY;
      OP_CLOSE:  cls = CLS_CLOSE;
      OP_PING:   cls = CLS_PING;
      OP_PONG:   cls = CLS_PONG;
      default:   cls = CLS_UNKNOWN;
    endcase
    return cls;
  endfunction

endpackage

@@ design/websocket_frame_decoder_unit.sv @@
// WebSocket (RFC 6455) receive-side frame parser. One received byte is taken per clock on
// the rx channel while rx_ready is high; header, extended length and masking key bytes
// are absorbed, and each text, binary, ping or pong payload byte gives one unmasked
// result on the res channel, with frame_last on the frame's final byte. A close frame
// gives a single end result and sets closing until reset; a zero-length frame gives one
// empty end result; frames with other opcodes give nothing. Each byte is decoded in the
// cycle it is accepted and its result is registered.
// A two-entry output register keeps rx_ready high while one result waits; rx_ready drops
// only when both entries are full.
module websocket_frame_decoder_unit
  import wsfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_ready,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  input  logic       res_ready,
  output logic       has_data,
  output logic [7:0] data_byte,
  output logic [2:0] frame_class,
  output logic       frame_last,
  output logic       fin_flag,
  output logic       closing
);

  phase_t      phase, phase_next;
  logic [7:0]  header_first, header_first_next;
  logic        masked, masked_next;
  logic [2:0]  ext_index, ext_index_next;
  logic [63:0] remaining, remaining_next;
  logic [31:0] mask_key, mask_key_next;
  logic [1:0]  key_pos, key_pos_next;
  logic        close_latched, close_latched_next;

  logic        emit;
  res_t        res;
  logic        hdr_done;
  logic [63:0] hdr_rem;
  logic [2:0]  cls;
  logic [7:0]  key_byte;
  logic        last;

  res_t        main_res, skid_res;
  logic        skid_valid;
  logic        accept, push, pop;

  assign accept = rx_valid && rx_ready;
  assign rx_ready = !skid_valid;

  always_comb begin
    phase_next         = phase;
    header_first_next  = header_first;
    masked_next        = masked;
    ext_index_next     = ext_index;
    remaining_next     = remaining;
    mask_key_next      = mask_key;
    key_pos_next       = key_pos;
    close_latched_next = close_latched;
    hdr_done           = 1'b0;
    hdr_rem            = remaining;
    emit               = 1'b0;
    res                = '0;
    cls                = class_of(header_first[3:0]);
    last               = (remaining == 64'd1);
    unique case (key_pos)
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase

    unique case (phase)
      PH_HDR1: begin
        masked_next   = rx_byte[7];
        key_pos_next  = 2'd0;
        mask_key_next = '0;
        if (rx_byte[6:0] == LEN_EXT16) begin
          remaining_next = '0;
          ext_index_next = 3'd1;
          phase_next     = PH_EXT;
        end else if (rx_byte[6:0] == LEN_EXT64) begin
          remaining_next = '0;
          ext_index_next = 3'd7;
          phase_next     = PH_EXT;
        end else begin
          remaining_next = {57'd0, rx_byte[6:0]};
          hdr_rem        = remaining_next;
          if (rx_byte[7]) begin
            phase_next = PH_KEY;
          end else begin
            hdr_done = 1'b1;
          end
        end
      end
      PH_EXT: begin
        remaining_next = {remaining[55:0], rx_byte};
        hdr_rem        = remaining_next;
        if (ext_index != 3'd0) begin
          ext_index_next = ext_index - 3'd1;
        end else if (masked) begin
          phase_next = PH_KEY;
        end else begin
          hdr_done = 1'b1;
        end
      end
      PH_KEY: begin
        mask_key_next = {mask_key[23:0], rx_byte};
        if (key_pos != 2'd3) begin
          key_pos_next = key_pos + 2'd1;
        end else begin
          hdr_done = 1'b1;
        end
      end
      PH_DATA: begin
        key_pos_next   = key_pos + 2'd1;
        remaining_next = remaining - 64'd1;
        if (last) begin
          phase_next = PH_HDR0;
        end
        res.fin_flag    = header_first[7];
        res.frame_class = cls;
        if (cls == CLS_CLOSE) begin
          if (last) begin
            close_latched_next = 1'b1;
            emit               = 1'b1;
            res.frame_last     = 1'b1;
          end
        end else if (cls != CLS_UNKNOWN) begin
          emit           = 1'b1;
          res.has_data   = 1'b1;
          res.data_byte  = masked ? (rx_byte ^ key_byte) : rx_byte;
          res.frame_last = last;
        end
      end
      default: begin
        header_first_next = rx_byte;
        phase_next        = PH_HDR1;
      end
    endcase

    // header complete: start payload or close off an empty frame
    if (hdr_done) begin
      key_pos_next = 2'd0;
      if (hdr_rem != 64'd0) begin
        phase_next = PH_DATA;
      end else begin
        phase_next      = PH_HDR0;
        res.fin_flag    = header_first[7];
        res.frame_class = cls;
        res.frame_last  = 1'b1;
        if (cls == CLS_CLOSE) begin
          close_latched_next = 1'b1;
        end
        emit = (cls != CLS_UNKNOWN);
      end
    end
    res.closing = close_latched_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HDR0;
      header_first  <= '0;
      masked        <= 1'b0;
      ext_index     <= '0;
      remaining     <= '0;
      mask_key      <= '0;
      key_pos       <= '0;
      close_latched <= 1'b0;
    end else if (accept) begin
      phase         <= phase_next;
      header_first  <= header_first_next;
      masked        <= masked_next;
      ext_index     <= ext_index_next;
      remaining     <= remaining_next;
      mask_key      <= mask_key_next;
      key_pos       <= key_pos_next;
      close_latched <= close_latched_next;
    end
  end

  // two-entry result buffer
  assign push = accept && emit;
  assign pop  = res_valid && res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        res_valid <= push;
      end
    end else if (!res_valid) begin
      res_valid <= push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && skid_valid) begin
      main_res <= skid_res;
    end else if (push && (pop || !res_valid)) begin
      main_res <= res;
    end
    if (push && res_valid && !pop) begin
      skid_res <= res;
    end
  end

  assign has_data    = main_res.has_data;
  assign data_byte   = main_res.data_byte;
  assign frame_class = main_res.frame_class;
  assign frame_last  = main_res.frame_last;
  assign fin_flag    = main_res.fin_flag;
  assign closing     = main_res.closing;

endmodule
